// ----- design/interval_booking_table_core_assert.svh -----
// Assertion macros used by the checker file of the booking table.
`ifndef INTERVAL_BOOKING_TABLE_CORE_ASSERT_SVH
`define INTERVAL_BOOKING_TABLE_CORE_ASSERT_SVH

// Clocked property that is switched off while reset is asserted.
`define IBT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked property that is also checked across reset.
`define IBT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

// ----- design/ibt_pkg.sv -----
// Package with the types, constants and tree sizing functions of the booking table.
`timescale 1ns / 1ps

package ibt_pkg;

  // Default sizes of the table.
  localparam int CAPACITY_DEF  = 1024;
  localparam int TIME_BITS_DEF = 31;

  // Fixed widths of the result fields.
  localparam int STATUS_BITS = 2;
  localparam int USED_BITS   = 11;

  // Fan-in of one node of the registered clash reduction tree.
  localparam int FAN_IN = 32;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Request sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT
  } state_t;

  // Number of nodes at a given level of the tree; level zero is the leaves.
  function automatic int level_width(input int n, input int l);
    int w;
    w = n;
    for (int k = 0; k < 16; k++) begin
      if (k < l) begin
        w = (w + FAN_IN - 1) / FAN_IN;
      end
    end
    return w;
  endfunction

  // Number of registered levels needed to reduce n leaves to one bit.
  function automatic int tree_levels(input int n);
    int w;
    int lv;
    w  = n;
    lv = 0;
    for (int k = 0; k < 16; k++) begin
      if (w > 1) begin
        w  = (w + FAN_IN - 1) / FAN_IN;
        lv = lv + 1;
      end
    end
    return lv;
  endfunction

  // Position of the first node of a level when all levels are laid end to end.
  function automatic int level_base(input int n, input int l);
    int acc;
    acc = 0;
    for (int k = 0; k < 16; k++) begin
      if (k < l) begin
        acc = acc + level_width(n, k);
      end
    end
    return acc;
  endfunction

endpackage

// ----- design/interval_booking_table_core.sv -----
// Top level of the interval booking table: cell chain, clash tree and sequencer.
`timescale 1ns / 1ps
// Reservation table of non-overlapping half-open intervals [start, end),
// kept sorted by start in a chain of CAPACITY cells.
// Requests: drive in_slot_start and in_slot_end with start high; the beat is
// taken at a clock edge where busy is low. busy stays high until the result
// has been produced.
// Results: one beat per request, shown for exactly one cycle while out_strobe
// is high, with out_status (booked, overlap, full) and out_entries_used, the
// count after the request. The receiver cannot stall; out_strobe is never
// held.
// Timing: every cell compares the request in parallel, and the clash flags
// are merged by a registered OR tree of L = ceil(log32(CAPACITY)) levels
// (two for 1024 entries). A request is answered once the registered cell
// clash flags and the clash tree have settled, and the block takes no new
// request until the previous one has been answered. A request to a full
// table skips the search and goes straight to the commit state.
// Insertion shifts the whole chain at once, in the commit state.
// Reset: clears the entry count, sequencer and strobe; stored intervals need
// no clearing as only the first count cells are ever consulted.

module interval_booking_table_core
  import ibt_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [TIME_BITS-1:0]   in_slot_start,
  input  logic [TIME_BITS-1:0]   in_slot_end,
  output logic                   out_strobe,
  output logic [STATUS_BITS-1:0] out_status,
  output logic [USED_BITS-1:0]   out_entries_used
);

  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int LEVELS    = tree_levels(CAPACITY);
  localparam int WAIT_BITS = $clog2(LEVELS + 1);

  state_t                 state_r, state_nxt;
  logic [WAIT_BITS-1:0]   wait_r, wait_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;
  logic [TIME_BITS-1:0]   req_start_r;
  logic [TIME_BITS-1:0]   req_end_r;
  logic                   out_strobe_r, out_strobe_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [USED_BITS-1:0]   out_used_r, out_used_nxt;

  logic                   accept;
  logic                   commit;
  logic                   table_full;
  logic                   any_clash;
  logic                   insert_en;

  logic [CAPACITY-1:0]    occupied;
  logic [CAPACITY-1:0]    clash_flags;
  logic [CAPACITY-1:0]    cell_aoa;
  logic [TIME_BITS-1:0]   cell_start [CAPACITY];
  logic [TIME_BITS-1:0]   cell_end   [CAPACITY];

  assign accept     = start && !busy;
  assign table_full = (count_r == CNT_BITS'(CAPACITY));

  // Cell chain: each cell sees its predecessor's entry and position flag.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 prev_aoa;
    logic [TIME_BITS-1:0] prev_start;
    logic [TIME_BITS-1:0] prev_end;

    assign occupied[i] = (CNT_BITS'(i) < count_r);

    if (i == 0) begin : g_head
      assign prev_aoa   = 1'b0;
      assign prev_start = '0;
      assign prev_end   = '0;
    end else begin : g_link
      assign prev_aoa   = cell_aoa[i-1];
      assign prev_start = cell_start[i-1];
      assign prev_end   = cell_end[i-1];
    end

    ibt_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .req_start (req_start_r),
      .req_end   (req_end_r),
      .occupied  (occupied[i]),
      .insert_en (insert_en),
      .prev_aoa  (prev_aoa),
      .prev_start(prev_start),
      .prev_end  (prev_end),
      .aoa       (cell_aoa[i]),
      .start_o   (cell_start[i]),
      .end_o     (cell_end[i]),
      .clash_o   (clash_flags[i])
    );
  end

  // Merge the clash flags of all cells.
  ibt_or_tree #(
    .N(CAPACITY)
  ) u_tree (
    .clk   (clk),
    .leaves(clash_flags),
    .any_o (any_clash)
  );

  // Sequencer next state: a full table is answered at once, otherwise wait
  // for the clash tree to settle.
  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          wait_nxt  = WAIT_BITS'(LEVELS);
          state_nxt = table_full ? S_COMMIT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (wait_r == '0) begin
          state_nxt = S_COMMIT;
        end else begin
          wait_nxt = wait_r - 1'b1;
        end
      end
      S_COMMIT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy   = 1'b1;
    commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_SEARCH: begin
        busy = 1'b1;
      end
      S_COMMIT: begin
        commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Decide the result and whether the chain takes the new interval.
  always_comb begin
    insert_en      = 1'b0;
    count_nxt      = count_r;
    out_strobe_nxt = commit;
    out_status_nxt = out_status_r;
    out_used_nxt   = out_used_r;
    if (commit) begin
      if (table_full) begin
        out_status_nxt = ST_FULL;
      end else if (any_clash) begin
        out_status_nxt = ST_OVERLAP;
      end else begin
        out_status_nxt = ST_BOOKED;
        insert_en      = 1'b1;
        count_nxt      = count_r + 1'b1;
      end
      out_used_nxt = USED_BITS'(count_nxt);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wait_r       <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wait_r       <= wait_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_start_r <= in_slot_start;
      req_end_r   <= in_slot_end;
    end
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_entries_used = out_used_r;

endmodule

// ----- design/ibt_cell.sv -----
// One table cell: holds one booked interval, tests the request and shifts on insert.
`timescale 1ns / 1ps

module ibt_cell
  import ibt_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic [TIME_BITS-1:0] req_start,
  input  logic [TIME_BITS-1:0] req_end,
  input  logic                 occupied,
  input  logic                 insert_en,
  input  logic                 prev_aoa,
  input  logic [TIME_BITS-1:0] prev_start,
  input  logic [TIME_BITS-1:0] prev_end,
  output logic                 aoa,
  output logic [TIME_BITS-1:0] start_o,
  output logic [TIME_BITS-1:0] end_o,
  output logic                 clash_o
);

  logic [TIME_BITS-1:0] start_r;
  logic [TIME_BITS-1:0] end_r;
  logic                 clash_r;
  logic                 place;
  logic                 clash;

  // A free cell, or one whose start is not below the request, lies at or after
  // the insertion point. The point itself is where the predecessor says no.
  assign aoa   = !occupied || (start_r >= req_start);
  assign place = aoa && !prev_aoa;

  // Only the cell at the insertion point can report a clash: either its
  // predecessor runs past the new start, or its own interval overlaps.
  assign clash = place && ((prev_end > req_start) ||
                           (occupied && (req_start < end_r) && (req_end > start_r)));

  // Clash flag for the reduction tree.
  always_ff @(posedge clk) begin
    clash_r <= clash;
  end

  // On insert, cells past the point take their neighbour's entry and the
  // cell at the point takes the request.
  always_ff @(posedge clk) begin
    if (insert_en) begin
      if (prev_aoa) begin
        start_r <= prev_start;
        end_r   <= prev_end;
      end else if (place) begin
        start_r <= req_start;
        end_r   <= req_end;
      end
    end
  end

  assign start_o = start_r;
  assign end_o   = end_r;
  assign clash_o = clash_r;

endmodule

// ----- design/ibt_or_tree.sv -----
// Registered OR reduction tree that merges the clash flags of all cells.
`timescale 1ns / 1ps

module ibt_or_tree
  import ibt_pkg::*;
#(
  parameter int N = CAPACITY_DEF
) (
  input  logic         clk,
  input  logic [N-1:0] leaves,
  output logic         any_o
);

  localparam int LEVELS  = tree_levels(N);
  localparam int TOTAL_R = level_base(N, LEVELS + 1) - N;

  logic [TOTAL_R-1:0]   node_d;
  logic [TOTAL_R-1:0]   node_r;
  logic [N+TOTAL_R-1:0] avail;

  // Leaves and all registered levels side by side.
  assign avail = {node_r, leaves};

  // Each node ORs up to FAN_IN nodes of the level below it.
  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int WP = level_width(N, l - 1);
    localparam int WC = level_width(N, l);
    localparam int BP = level_base(N, l - 1);
    localparam int BC = level_base(N, l) - N;
    for (genvar j = 0; j < WC; j++) begin : g_node
      localparam int LO = j * FAN_IN;
      localparam int HI = (LO + FAN_IN < WP) ? (LO + FAN_IN - 1) : (WP - 1);
      assign node_d[BC + j] = |avail[BP + HI : BP + LO];
    end
  end

  // One register stage per level.
  always_ff @(posedge clk) begin
    node_r <= node_d;
  end

  assign any_o = node_r[TOTAL_R-1];

endmodule

// ----- design/ibt_checker.sv -----
// Port-level checker for the booking table and its bind to the top level.
`timescale 1ns / 1ps
`include "interval_booking_table_core_assert.svh"

module ibt_checker
  import ibt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [1:0] out_status
);

  logic status_known;

  // The reported status is one of the defined codes.
  assign status_known = (out_status == ST_BOOKED) || (out_status == ST_OVERLAP) ||
                        (out_status == ST_FULL);

  // A taken request makes the block busy in the next cycle.
  `IBT_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted beat did not raise busy")
  // A result beat appears only once the block is free again.
  `IBT_ASSERT(a_strobe_idle, clk, rst_n, out_strobe |-> !busy, "result beat while busy")
  // Each result beat lasts exactly one cycle.
  `IBT_ASSERT(a_strobe_single, clk, rst_n, out_strobe |=> !out_strobe, "result beat held too long")
  // Every result beat carries a defined status code.
  `IBT_ASSERT(a_status_code, clk, rst_n, out_strobe |-> status_known, "undefined status code")
  // Reset leaves the block idle with no result beat.
  `IBT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!busy && !out_strobe), "block not idle after reset")

endmodule

bind interval_booking_table_core ibt_checker u_ibt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .out_status(out_status)
);
